// File: hdl/drc_pkg.sv
package drc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   // count runs 0..TABLE_DEPTH
   localparam int CNT_W = IDX_W + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [CSR_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd1280;
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd720;

   // one table entry: signed origin, unsigned size
   typedef struct packed {
      logic signed [14:0] x;
      logic signed [14:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
   } drc_entry_type;

   localparam int ENTRY_W = $bits(drc_entry_type);

   typedef struct packed {
      logic             latch_req;
      logic             ram_we;
      logic             wr_sel_merge;  // 1: merged box, 0: new request rect
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
      logic             out_load;
      logic             out_last;
   } drc_cmd_type;

   typedef struct packed {
      logic req_cmd;
      logic req_size_ok;
      logic hit;
      logic out_free;
   } drc_stat_type;

endpackage

// File: hdl/drc_req_if.sv
interface drc_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [14:0] in_x;
   logic signed [14:0] in_y;
   logic signed [14:0] in_width;
   logic signed [14:0] in_height;

   modport source (output valid, command, in_x, in_y, in_width, in_height, input ready);
   modport sink   (input valid, command, in_x, in_y, in_width, in_height, output ready);
endinterface

// File: hdl/drc_rsp_if.sv
interface drc_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] out_x;
   logic [13:0] out_y;
   logic [12:0] out_width;
   logic [12:0] out_height;
   logic        last_of_run;

   modport source (output valid, out_x, out_y, out_width, out_height, last_of_run,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_width, out_height, last_of_run,
                   output ready);
endinterface

// File: hdl/drc_ram.sv
module drc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/drc_ctrl.sv
module drc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  drc_pkg::drc_stat_type stat,
   output drc_pkg::drc_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_APPEND = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_MERGE0 = 5'b01000,
      ST_FLUSH  = 5'b10000
   } drc_state_type;

   drc_state_type                state_ff, state_in;
   logic [drc_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [drc_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         last;
   logic                         full;
   logic [drc_pkg::IDX_W-1:0]    idx_next;

   assign last     = ((drc_pkg::CNT_W'(idx_ff) + drc_pkg::CNT_W'(1)) == count_ff);
   assign full     = (count_ff == drc_pkg::CNT_W'(drc_pkg::TABLE_DEPTH));
   assign idx_next = idx_ff + drc_pkg::IDX_W'(1);

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      count_in         = count_ff;
      req_ready        = 1'b0;
      cmd.latch_req    = 1'b0;
      cmd.ram_we       = 1'b0;
      cmd.wr_sel_merge = 1'b0;
      cmd.wr_addr      = count_ff[drc_pkg::IDX_W-1:0];
      cmd.rd_addr      = '0;
      cmd.out_load     = 1'b0;
      cmd.out_last     = last;

      unique case (state_ff)
         ST_IDLE: begin
            // address 0 is read all along so entry 0 is ready the cycle after accept
            req_ready = 1'b1;
            idx_in    = '0;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               if (stat.req_cmd == drc_pkg::CMD_FLUSH) begin
                  if (count_ff != '0) begin
                     state_in = ST_FLUSH;
                  end
               end else if (stat.req_size_ok) begin
                  if (count_ff == '0) begin
                     state_in = ST_APPEND;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_APPEND: begin
            cmd.ram_we = 1'b1;
            count_in   = count_ff + drc_pkg::CNT_W'(1);
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.rd_addr = last ? '0 : idx_next;
            if (stat.hit) begin
               cmd.ram_we       = 1'b1;
               cmd.wr_sel_merge = 1'b1;
               cmd.wr_addr      = idx_ff;
               state_in         = ST_IDLE;
            end else if (last) begin
               if (full) begin
                  state_in = ST_MERGE0;
               end else begin
                  cmd.ram_we = 1'b1;
                  count_in   = count_ff + drc_pkg::CNT_W'(1);
                  state_in   = ST_IDLE;
               end
            end else begin
               idx_in = idx_next;
            end
         end
         ST_MERGE0: begin
            cmd.ram_we       = 1'b1;
            cmd.wr_sel_merge = 1'b1;
            cmd.wr_addr      = '0;
            state_in         = ST_IDLE;
         end
         ST_FLUSH: begin
            cmd.rd_addr = idx_ff;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_addr = idx_next;
                  idx_in      = idx_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/drc_dp.sv
module drc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_command,
   input  logic signed [14:0]                  req_x,
   input  logic signed [14:0]                  req_y,
   input  logic signed [14:0]                  req_width,
   input  logic signed [14:0]                  req_height,
   input  logic                                csr_wr_en,
   input  logic [drc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  drc_pkg::drc_cmd_type                cmd,
   output drc_pkg::drc_stat_type               stat,
   drc_rsp_if.source                           rsp_chan
);

   typedef struct packed {
      logic [13:0] pos;
      logic [12:0] len;
   } clip_type;

   function automatic clip_type clip_edge(input logic signed [14:0] pos,
                                          input logic [15:0] len,
                                          input logic [12:0] limit);
      logic signed [18:0] p;
      logic signed [18:0] s;
      logic signed [18:0] lim;
      clip_type           r;
      p   = {{4{pos[14]}}, pos};
      s   = {3'b000, len};
      lim = {6'b000000, limit};
      if (p < 0) begin
         s = s + p;
         p = '0;
      end
      if (p + s > lim) begin
         s = lim - p;
      end
      if (s < 0) begin
         s = '0;
      end
      r.pos = p[13:0];
      r.len = s[12:0];
      return r;
   endfunction

   logic signed [14:0]              rx_ff, ry_ff;
   logic [14:0]                     rw_ff, rh_ff;
   logic [drc_pkg::CSR_DATA_W-1:0]  scr_w_ff, scr_h_ff;

   drc_pkg::drc_entry_type          ent;
   drc_pkg::drc_entry_type          new_ent;
   drc_pkg::drc_entry_type          merged;
   logic [drc_pkg::ENTRY_W-1:0]     rd_data;

   logic signed [17:0] ax1, ay1, ax2, ay2;
   logic signed [17:0] bx1, by1, bx2, by2;
   logic signed [17:0] mx1, my1, mx2, my2;
   logic signed [17:0] mw, mh;

   clip_type  cx, cy;

   logic        rsp_valid_ff;
   logic [13:0] rsp_x_ff, rsp_y_ff;
   logic [12:0] rsp_w_ff, rsp_h_ff;
   logic        rsp_last_ff;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         rx_ff <= req_x;
         ry_ff <= req_y;
         rw_ff <= req_width;
         rh_ff <= req_height;
      end
   end

   // screen size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= drc_pkg::SCREEN_WIDTH_RST;
         scr_h_ff <= drc_pkg::SCREEN_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            drc_pkg::CSR_SCREEN_WIDTH:  scr_w_ff <= csr_wdata;
            drc_pkg::CSR_SCREEN_HEIGHT: scr_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign stat.req_cmd     = req_command;
   assign stat.req_size_ok = !req_width[14] && (req_width != '0) &&
                             !req_height[14] && (req_height != '0);

   assign ent = drc_pkg::drc_entry_type'(rd_data);

   assign ax1 = {{3{rx_ff[14]}}, rx_ff};
   assign ay1 = {{3{ry_ff[14]}}, ry_ff};
   assign ax2 = ax1 + {3'b000, rw_ff};
   assign ay2 = ay1 + {3'b000, rh_ff};
   assign bx1 = {{3{ent.x[14]}}, ent.x};
   assign by1 = {{3{ent.y[14]}}, ent.y};
   assign bx2 = bx1 + {2'b00, ent.w};
   assign by2 = by1 + {2'b00, ent.h};

   // inclusive edges: touching counts as a hit
   assign stat.hit = (ax1 <= bx2) && (ax2 >= bx1) && (ay1 <= by2) && (ay2 >= by1);

   assign mx1 = (ax1 < bx1) ? ax1 : bx1;
   assign my1 = (ay1 < by1) ? ay1 : by1;
   assign mx2 = (ax2 > bx2) ? ax2 : bx2;
   assign my2 = (ay2 > by2) ? ay2 : by2;
   assign mw  = mx2 - mx1;
   assign mh  = my2 - my1;

   assign merged.x = mx1[14:0];
   assign merged.y = my1[14:0];
   assign merged.w = mw[15:0];
   assign merged.h = mh[15:0];

   assign new_ent.x = rx_ff;
   assign new_ent.y = ry_ff;
   assign new_ent.w = {1'b0, rw_ff};
   assign new_ent.h = {1'b0, rh_ff};

   drc_ram #(
      .WIDTH (drc_pkg::ENTRY_W),
      .DEPTH (drc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_sel_merge ? merged : new_ent),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign cx = clip_edge(ent.x, ent.w, scr_w_ff);
   assign cy = clip_edge(ent.y, ent.h, scr_h_ff);

   // output register
   assign stat.out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_x_ff    <= cx.pos;
         rsp_y_ff    <= cy.pos;
         rsp_w_ff    <= cx.len;
         rsp_h_ff    <= cy.len;
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_x       = rsp_x_ff;
   assign rsp_chan.out_y       = rsp_y_ff;
   assign rsp_chan.out_width   = rsp_w_ff;
   assign rsp_chan.out_height  = rsp_h_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

endmodule

// File: hdl/dirty_rect_coalescer.sv
// Dirty rectangle coalescer. An add request (command 0) with positive width
// and height is compared against the stored rectangles in table order, one
// entry per clock through the table RAM's read port; the first entry it
// overlaps or touches (edges inclusive) grows to the bounding box of both,
// otherwise the rectangle is appended, or merged into entry 0 if all
// TABLE_DEPTH entries are in use. A flush request (command 1) streams every
// stored rectangle out, clipped to screen_width x screen_height, with
// last_of_run on the final one, and empties the table; an empty flush sends
// nothing. A flush sends one result per clock while the sink is ready. The
// table RAM is not cleared after reset; no warm-up time is needed.
module dirty_rect_coalescer (
   input  logic                            clock,
   input  logic                            reset,
   drc_req_if.sink                         req_chan,
   drc_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [drc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [drc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   drc_pkg::drc_cmd_type  cmd;
   drc_pkg::drc_stat_type stat;
   logic                  ready;

   // sequencer: scan / append / merge / flush control, table count
   drc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = ready;

   // datapath: request latch, table RAM, compare/merge, clipping, output register
   drc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_chan.command),
      .req_x       (req_chan.in_x),
      .req_y       (req_chan.in_y),
      .req_width   (req_chan.in_width),
      .req_height  (req_chan.in_height),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_chan    (rsp_chan)
   );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request or result moving
   localparam int SETTLE_CYCLES  = 80;    // > worst add search plus margin

   // one request as the sender sees it
   typedef struct {
      logic               command;
      logic signed [14:0] x;
      logic signed [14:0] y;
      logic signed [14:0] w;
      logic signed [14:0] h;
   } rect_request_type;

   // one stored dirty rectangle, same widths as the table entry
   typedef struct {
      logic signed [14:0] x;
      logic signed [14:0] y;
      logic [15:0]        w;
      logic [15:0]        h;
   } dirty_box_type;

   // one flushed rectangle
   typedef struct {
      logic [13:0] x;
      logic [13:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic        last;
   } clipped_rect_type;

   logic clock;
   logic reset;
   logic                           csr_wr_en;
   logic [drc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [drc_pkg::CSR_DATA_W-1:0] csr_wdata;

   drc_req_if req_bus ();
   drc_rsp_if rsp_bus ();

   dirty_rect_coalescer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Shadow copy of the rectangle table and the screen size
   // ---------------------------------------------------------------
   dirty_box_type      shadow_boxes [drc_pkg::TABLE_DEPTH];
   int                 shadow_count;
   logic [12:0]        shadow_scr_width;
   logic [12:0]        shadow_scr_height;

   rect_request_type   pending_requests [$];   // filled by the stimulus process
   clipped_rect_type   expected_rects [$];     // flushed rectangles not yet seen

   int queued_count;
   int accepted_count;
   int result_count;
   int mismatch_count;
   int send_idle_pct;
   int recv_stall_pct;
   int send_gap;
   int hold_left;
   int quiet_cycles;

   // Grow a stored box to the bounding box of itself and (x1,y1)-(x2,y2).
   function automatic dirty_box_type grow_box(dirty_box_type b, int x1, int y1, int x2,
                                              int y2);
      int bx1, by1, bx2, by2;
      dirty_box_type r;
      bx1 = int'(b.x);
      by1 = int'(b.y);
      bx2 = bx1 + int'(b.w);
      by2 = by1 + int'(b.h);
      if (bx1 < x1) x1 = bx1;
      if (by1 < y1) y1 = by1;
      if (bx2 > x2) x2 = bx2;
      if (by2 > y2) y2 = by2;
      r.x = 15'(x1);
      r.y = 15'(y1);
      r.w = 16'(x2 - x1);
      r.h = 16'(y2 - y1);
      return r;
   endfunction

   // Apply one accepted request to the shadow table; a flush queues its output.
   task automatic apply_request(input rect_request_type r);
      int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      int x, y, w, h, scr_w, scr_h;
      int hit;
      clipped_rect_type c;
      if (r.command == drc_pkg::CMD_FLUSH) begin
         scr_w = int'(shadow_scr_width);
         scr_h = int'(shadow_scr_height);
         for (int i = 0; i < shadow_count; i++) begin
            x = int'(shadow_boxes[i].x);
            y = int'(shadow_boxes[i].y);
            w = int'(shadow_boxes[i].w);
            h = int'(shadow_boxes[i].h);
            if (x < 0) begin
               w += x;
               x = 0;
            end
            if (y < 0) begin
               h += y;
               y = 0;
            end
            if (x + w > scr_w) w = scr_w - x;
            if (y + h > scr_h) h = scr_h - y;
            if (w < 0) w = 0;
            if (h < 0) h = 0;
            c.x = x[13:0];
            c.y = y[13:0];
            c.w = w[12:0];
            c.h = h[12:0];
            c.last = (i == shadow_count - 1);
            expected_rects.push_back(c);
         end
         shadow_count = 0;
         return;
      end
      ax1 = int'(r.x);
      ay1 = int'(r.y);
      // non-positive size: dropped
      if (int'(r.w) <= 0 || int'(r.h) <= 0) return;
      ax2 = ax1 + int'(r.w);
      ay2 = ay1 + int'(r.h);
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0) begin
            bx1 = int'(shadow_boxes[i].x);
            by1 = int'(shadow_boxes[i].y);
            bx2 = bx1 + int'(shadow_boxes[i].w);
            by2 = by1 + int'(shadow_boxes[i].h);
            // inclusive edges: touching counts as a hit
            if (ax1 <= bx2 && ax2 >= bx1 && ay1 <= by2 && ay2 >= by1) hit = i;
         end
      end
      if (hit >= 0) begin
         shadow_boxes[hit] = grow_box(shadow_boxes[hit], ax1, ay1, ax2, ay2);
      end else if (shadow_count < drc_pkg::TABLE_DEPTH) begin
         shadow_boxes[shadow_count].x = r.x;
         shadow_boxes[shadow_count].y = r.y;
         shadow_boxes[shadow_count].w = 16'(ax2 - ax1);
         shadow_boxes[shadow_count].h = 16'(ay2 - ay1);
         shadow_count++;
      end else begin
         // table full: fold into entry 0
         shadow_boxes[0] = grow_box(shadow_boxes[0], ax1, ay1, ax2, ay2);
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Request driver: pops pending requests, predicts on acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            // accepted this edge: predict from what the block actually saw
            apply_request('{req_bus.command, req_bus.in_x, req_bus.in_y,
                            req_bus.in_width, req_bus.in_height});
            accepted_count++;
         end
         if (send_gap != 0 || pending_requests.size() == 0) begin
            req_bus.valid <= 1'b0;
            if (send_gap != 0) send_gap <= send_gap - 1;
         end else begin
            req_bus.valid     <= 1'b1;
            req_bus.command   <= pending_requests[0].command;
            req_bus.in_x      <= pending_requests[0].x;
            req_bus.in_y      <= pending_requests[0].y;
            req_bus.in_width  <= pending_requests[0].w;
            req_bus.in_height <= pending_requests[0].h;
            void'(pending_requests.pop_front());
            send_gap <= ($urandom_range(0, 99) < send_idle_pct) ? gap_length() : 0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor: random backpressure, field-by-field compare
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rects.size() == 0) begin
               report_mismatch($sformatf("result %0d with none expected (x=%0d y=%0d)",
                                         result_count, rsp_bus.out_x, rsp_bus.out_y));
            end else begin
               if (rsp_bus.out_x !== expected_rects[0].x)
                  report_mismatch($sformatf("result %0d out_x got %0d want %0d", result_count,
                                            rsp_bus.out_x, expected_rects[0].x));
               if (rsp_bus.out_y !== expected_rects[0].y)
                  report_mismatch($sformatf("result %0d out_y got %0d want %0d", result_count,
                                            rsp_bus.out_y, expected_rects[0].y));
               if (rsp_bus.out_width !== expected_rects[0].w)
                  report_mismatch($sformatf("result %0d out_width got %0d want %0d",
                                            result_count, rsp_bus.out_width,
                                            expected_rects[0].w));
               if (rsp_bus.out_height !== expected_rects[0].h)
                  report_mismatch($sformatf("result %0d out_height got %0d want %0d",
                                            result_count, rsp_bus.out_height,
                                            expected_rects[0].h));
               if (rsp_bus.last_of_run !== expected_rects[0].last)
                  report_mismatch($sformatf("result %0d last_of_run got %0b want %0b",
                                            result_count, rsp_bus.last_of_run,
                                            expected_rects[0].last));
               void'(expected_rects.pop_front());
            end
            result_count++;
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < recv_stall_pct) hold_left <= gap_length();
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: too long without any request or result moving
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic queue_request(input rect_request_type r);
      pending_requests.push_back(r);
      queued_count++;
   endtask

   task automatic queue_add(input int x, input int y, input int w, input int h);
      queue_request('{drc_pkg::CMD_ADD, x[14:0], y[14:0], w[14:0], h[14:0]});
   endtask

   // flush with junk in the rectangle fields, which the block must ignore
   task automatic queue_flush();
      queue_request('{drc_pkg::CMD_FLUSH, 15'($urandom), 15'($urandom), 15'($urandom),
                      15'($urandom)});
   endtask

   function automatic int extreme15();
      case ($urandom_range(0, 3))
         0: return -16384;
         1: return -1;
         2: return 0;
         default: return 16383;
      endcase
   endfunction

   // Random add: mostly on or near the screen so boxes overlap and merge.
   task automatic queue_random_add();
      int pick, span_x, span_y, max_w, max_h;
      pick   = $urandom_range(0, 99);
      span_x = int'(shadow_scr_width) + 200;
      span_y = int'(shadow_scr_height) + 200;
      max_w  = int'(shadow_scr_width) / 4 + 20;
      max_h  = int'(shadow_scr_height) / 4 + 20;
      if (pick < 65) begin
         queue_add($urandom_range(0, span_x) - 100, $urandom_range(0, span_y) - 100,
                   $urandom_range(1, max_w), $urandom_range(1, max_h));
      end else if (pick < 77) begin
         // anything the fields allow, size sign included
         queue_add($urandom, $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
         queue_add(extreme15(), extreme15(),
                   ($urandom_range(0, 1) != 0) ? 16383 : $urandom_range(1, 16383),
                   ($urandom_range(0, 1) != 0) ? 1 : $urandom_range(1, 16383));
      end else if ($urandom_range(0, 1) != 0) begin
         queue_add($urandom_range(0, span_x), $urandom_range(0, span_y),
                   -int'($urandom_range(0, 16384)), $urandom_range(1, max_h));
      end else begin
         queue_add($urandom_range(0, span_x), $urandom_range(0, span_y),
                   $urandom_range(1, max_w), -int'($urandom_range(0, 16384)));
      end
   endtask

   // Returns at a falling edge once every request is in and every result out.
   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_rects.size() != 0);
   endtask

   task automatic write_screen(input logic [12:0] w, input logic [12:0] h);
      wait_drained();
      // an ignored or merging add may still be searching the table
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= drc_pkg::CSR_SCREEN_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= drc_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_scr_width = w;
      shadow_scr_height = h;
      @(negedge clock);
   endtask

   // Bursts of adds closed by a flush; optionally one full-table burst and
   // one point where the sender holds off until all results are back.
   task automatic run_random_phase(input int n_items, input bit fill_table,
                                   input bit hold_midway);
      int made, burst, gx, gy;
      bit held;
      made = 0;
      held = 0;
      if (fill_table) begin
         // 64 boxes on a 40-pixel grid, never touching each other
         for (int i = 0; i < drc_pkg::TABLE_DEPTH; i++) begin
            gx = (i % 8) * 40 - 100;
            gy = (i / 8) * 40 - 100;
            queue_add(gx, gy, $urandom_range(1, 38), $urandom_range(1, 38));
         end
         queue_add(-100 + 40 * 1 + 2, -100 + 40 * 1 + 2, 3, 3);  // hits entry 9 if that box is 2 or more wide and high
         queue_add(5000, 5000, 10, 10);                          // full: folds into entry 0
         queue_add(6000, -50, 5, 5);                             // misses grown entry 0: full, folds into entry 0 too
         queue_flush();
         made = drc_pkg::TABLE_DEPTH + 4;
      end
      while (made < n_items) begin
         burst = $urandom_range(0, 12);  // zero gives an empty flush
         for (int i = 0; i < burst; i++) queue_random_add();
         queue_flush();
         made += burst + 1;
         if (hold_midway && !held && made >= n_items / 2) begin
            held = 1;
            wait_drained();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = drc_pkg::CSR_SCREEN_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.command = drc_pkg::CMD_ADD;
      req_bus.in_x = '0;
      req_bus.in_y = '0;
      req_bus.in_width = '0;
      req_bus.in_height = '0;
      rsp_bus.ready = 1'b0;
      shadow_count = 0;
      shadow_scr_width = drc_pkg::SCREEN_WIDTH_RST;
      shadow_scr_height = drc_pkg::SCREEN_HEIGHT_RST;
      queued_count = 0;
      accepted_count = 0;
      result_count = 0;
      mismatch_count = 0;
      send_idle_pct = 30;
      recv_stall_pct = 30;
      quiet_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part on a 1280 x 720 screen
      write_screen(13'd1280, 13'd720);
      queue_flush();                          // empty table: nothing comes out
      queue_add(5, 5, 0, 10);                 // zero width: ignored
      queue_add(5, 5, 10, -1);                // negative height: ignored
      queue_add(0, 0, -16384, -16384);        // most negative sizes: ignored
      queue_add(0, 0, 10, 10);
      queue_add(10, 10, 5, 5);                // corners touch: merges to 0,0 15x15
      queue_add(16, 0, 4, 4);                 // one pixel clear: appended
      queue_add(-16384, -16384, 16383, 16383);// fully off to the top left
      queue_add(16383, 16383, 16383, 16383);  // fully off to the bottom right
      queue_add(-50, 600, 100, 200);          // clipped left and bottom
      queue_add(1200, -30, 16383, 50);        // clipped right and top
      queue_add(2000, 10, 50, 50);            // overlaps the previous box: merges into it
      queue_flush();
      queue_add(100, 100, 50, 50);
      queue_add(150, 120, 10, 10);            // touches right edge: merges
      queue_add(90, 90, 5, 5);                // just misses: appended
      queue_flush();
      queue_add(-16384, 0, 1, 1);
      queue_flush();                          // single rectangle, marked last
      queue_flush();                          // empty again

      // random phases over several screen sizes and idling patterns
      write_screen(13'd1, 13'd1);
      run_random_phase(55, 1'b0, 1'b1);

      send_idle_pct = 0;                      // a stretch with no idling at all
      recv_stall_pct = 0;
      write_screen(13'd4096, 13'd4096);
      run_random_phase(75, 1'b1, 1'b0);

      send_idle_pct = 30;
      recv_stall_pct = 50;
      write_screen(13'd8191, 13'd0);          // out-of-range sizes are used as given
      run_random_phase(45, 1'b0, 1'b0);

      send_idle_pct = 20;
      recv_stall_pct = 20;
      write_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      run_random_phase(60, 1'b0, 1'b1);

      write_screen(13'd640, 13'd4096);
      run_random_phase(60, 1'b0, 1'b0);

      send_idle_pct = 50;
      recv_stall_pct = 20;
      write_screen(drc_pkg::SCREEN_WIDTH_RST, drc_pkg::SCREEN_HEIGHT_RST);
      run_random_phase(60, 1'b0, 1'b0);

      // let stray results show up before judging
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
